// File: rtl/gsp_pkg.sv
// shared types and constants for the two-species gillespie step block
// depends on nothing; every rtl file imports it
`timescale 1ns / 1ps
`default_nettype none

package gsp_pkg;

    localparam int RATE_COUNT      = 5;
    localparam int RATE_W          = 32;
    localparam int TIME_W          = 32;
    localparam int DRAW_W          = 32;
    localparam int DRAW_SHIFT      = 8;
    localparam int CNT_FIELD_W     = 16;
    localparam int IDX_FIELD_W     = 7;
    localparam int SCOUNT_W        = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int MAX_SAMPLES_DEF = 128;
    localparam int COUNT_BITS_DEF  = 16;

    localparam logic [SCOUNT_W-1:0] SAMPLE_COUNT_RST = 8'd121;
    localparam logic [TIME_W-1:0]   TIME_SAT         = '1;

    // lanes whose hazard uses species b
    localparam logic [RATE_COUNT-1:0] LANE_USES_B = 5'b01010;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_EVENT = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_A_DUP    = 3'd0,
        CFG_RATE_B_DUP    = 3'd1,
        CFG_RATE_A_LOSS   = 3'd2,
        CFG_RATE_B_LOSS   = 3'd3,
        CFG_RATE_A_TO_B   = 3'd4,
        CFG_END_TIME      = 3'd5,
        CFG_SAMPLE_COUNT  = 3'd6,
        CFG_UNUSED        = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]             mode;
        logic [IDX_FIELD_W-1:0] time_index;
        logic [TIME_W-1:0]      time_value;
        logic [CNT_FIELD_W-1:0] init_a;
        logic [CNT_FIELD_W-1:0] init_b;
        logic [DRAW_W-1:0]      exp_draw;
        logic [DRAW_W-1:0]      unif_draw;
    } in_beat_t;

    typedef struct packed {
        logic                   sample_valid;
        logic [IDX_FIELD_W-1:0] sample_index;
        logic [CNT_FIELD_W-1:0] count_a;
        logic [CNT_FIELD_W-1:0] count_b;
        logic                   extinct;
        logic                   finished;
        logic                   hazard_fault;
    } out_beat_t;

endpackage

`default_nettype wire

// File: rtl/gsp_mul.sv
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
// full product is the high register followed by the low shift register
`timescale 1ns / 1ps
`default_nettype none

module gsp_mul
    import gsp_pkg::*;
#(
    parameter int A_W = 32,
    parameter int B_W = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [A_W-1:0]   mcand,
    input  wire logic [B_W-1:0]   mplier,
    output logic                  busy,
    output logic [A_W+B_W-1:0]    product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   mcand_reg, mcand_next;
    logic [A_W-1:0]   hi_reg, hi_next;
    logic [B_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [A_W:0]     sum;

    always_comb
    begin
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        cnt_next   = cnt_reg;
        sum        = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
        if (start)
        begin
            mcand_next = mcand;
            hi_next    = '0;
            lo_next    = mplier;
            cnt_next   = CNT_W'(B_W);
        end
        else if (cnt_reg != '0)
        begin
            hi_next  = sum[A_W:1];
            lo_next  = {sum[0], lo_reg[B_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign busy    = (cnt_reg != '0);
    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

// File: rtl/gsp_div.sv
// restoring bit-serial divider, one quotient bit per cycle
// dividend shifts out of the quotient register as quotient bits shift in
`timescale 1ns / 1ps
`default_nettype none

module gsp_div
    import gsp_pkg::*;
#(
    parameter int N_W = 40,
    parameter int D_W = 51
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output logic                busy,
    output logic [N_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W-1:0]   dvs_reg, dvs_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [N_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             fits;

    always_comb
    begin
        dvs_next = dvs_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg, q_reg[N_W-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        diff     = trial - {1'b0, dvs_reg};
        if (start)
        begin
            dvs_next = divisor;
            rem_next = '0;
            q_next   = dividend;
            cnt_next = CNT_W'(N_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fits ? diff[D_W-1:0] : trial[D_W-1:0];
            q_next   = {q_reg[N_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;

endmodule

`default_nettype wire

// File: rtl/two_species_gillespie_step.sv
// top level of the two-species gillespie direct-method step
// uses gsp_pkg, gsp_mul (hazard lanes, draw scaling) and gsp_div (time step)
//
// A mode-0 (load sample time) or mode-1 (start run) beat gives no result. A
// mode-2 event beat passes through five bit-serial hazard multipliers, an
// accumulation of the cumulative hazards, a check step, the bit-serial divider
// that forms the time step (the 32-bit uniform scaling runs beside it), then a
// step to pick the reaction and a step to apply it. The input is stalled while
// an event is in progress; a finished result waits in the output register while
// the next beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module two_species_gillespie_step
    import gsp_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_beat_t             in_beat,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_beat_t                 out_beat,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [RATE_W-1:0]    cfg_data
);

    localparam int CB    = COUNT_BITS;
    localparam int HP_W  = RATE_W + CB;
    localparam int TOT_W = HP_W + 3;
    localparam int DVD_W = DRAW_W + DRAW_SHIFT;
    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int NS_W  = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (NS_W > SCOUNT_W) ? NS_W : SCOUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_CHK,
        ST_DIV,
        ST_UPD,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        RX_A_DUP  = 3'd0,
        RX_B_DUP  = 3'd1,
        RX_A_LOSS = 3'd2,
        RX_B_LOSS = 3'd3,
        RX_A_TO_B = 3'd4
    } rx_t;

    state_t            state_reg, state_next;
    logic [RATE_W-1:0] rate_reg [RATE_COUNT];
    logic [RATE_W-1:0] rate_next [RATE_COUNT];
    logic [TIME_W-1:0] end_time_reg, end_time_next;
    logic [SCOUNT_W-1:0] scount_reg, scount_next;

    logic [CB-1:0]     species_a_reg, species_a_next;
    logic [CB-1:0]     species_b_reg, species_b_next;
    logic [TIME_W-1:0] sim_time_reg, sim_time_next;
    logic [NS_W-1:0]   next_sample_reg, next_sample_next;
    logic              running_reg, running_next;

    logic [DRAW_W-1:0] exp_reg, exp_next;
    logic [DRAW_W-1:0] unif_reg, unif_next;
    logic [2:0]        sum_idx_reg, sum_idx_next;
    logic [TOT_W-1:0]  acc_reg, acc_next;
    logic [TOT_W-1:0]  cum_reg [RATE_COUNT];
    logic [TOT_W-1:0]  cum_next [RATE_COUNT];
    logic              fault_reg, fault_next;
    rx_t               rsel_reg, rsel_next;

    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_beat_reg, out_beat_next;

    logic [TIME_W-1:0] sample_times [MAX_SAMPLES];
    logic [TIME_W-1:0] mem_rd_reg;
    logic              mem_we;

    logic              lane_start;
    logic [RATE_COUNT-1:0] lane_busy;
    logic [HP_W-1:0]   haz [RATE_COUNT];
    logic              unit_start;
    logic              div_busy;
    logic              tmul_busy;
    logic [DVD_W-1:0]  quot;
    logic [TOT_W+DRAW_W-1:0] tprod;

    logic [TOT_W-1:0]  target;
    logic [TIME_W-1:0] dt;
    logic [TIME_W:0]   newt;
    logic [CMP_W-1:0]  n_used;
    logic              sample_hit;
    logic [CB-1:0]     a_inc, a_dec, b_inc, b_dec;
    logic [CB-1:0]     a_new, b_new;
    logic              extinct_now;
    logic              slot_free;

    for (genvar g = 0; g < RATE_COUNT; g++)
    begin : g_lane
        gsp_mul #(
            .A_W (RATE_W),
            .B_W (CB)
        ) u_haz (
            .clk     (clk),
            .rst_n   (rst_n),
            .start   (lane_start),
            .mcand   (rate_reg[g]),
            .mplier  (LANE_USES_B[g] ? species_b_reg : species_a_reg),
            .busy    (lane_busy[g]),
            .product (haz[g])
        );
    end

    gsp_div #(
        .N_W (DVD_W),
        .D_W (TOT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (unit_start),
        .dividend ({exp_reg, {DRAW_SHIFT{1'b0}}}),
        .divisor  (cum_reg[RATE_COUNT-1]),
        .busy     (div_busy),
        .quotient (quot)
    );

    gsp_mul #(
        .A_W (TOT_W),
        .B_W (DRAW_W)
    ) u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (unit_start),
        .mcand   (cum_reg[RATE_COUNT-1]),
        .mplier  (unif_reg),
        .busy    (tmul_busy),
        .product (tprod)
    );

    always_comb
    begin
        target     = tprod[TOT_W+DRAW_W-1:DRAW_W];
        dt         = (quot[DVD_W-1:TIME_W] != '0) ? TIME_SAT : quot[TIME_W-1:0];
        newt       = {1'b0, sim_time_reg} + {1'b0, dt};
        n_used     = (CMP_W'(scount_reg) > CMP_W'(MAX_SAMPLES)) ?
                     CMP_W'(MAX_SAMPLES) : CMP_W'(scount_reg);
        sample_hit = (CMP_W'(next_sample_reg) < n_used) && (sim_time_reg >= mem_rd_reg);
        a_inc      = (species_a_reg == '1) ? species_a_reg : species_a_reg + 1'b1;
        b_inc      = (species_b_reg == '1) ? species_b_reg : species_b_reg + 1'b1;
        a_dec      = (species_a_reg == '0) ? species_a_reg : species_a_reg - 1'b1;
        b_dec      = (species_b_reg == '0) ? species_b_reg : species_b_reg - 1'b1;
        a_new      = species_a_reg;
        b_new      = species_b_reg;
        case (rsel_reg)
            RX_A_DUP:  a_new = a_inc;
            RX_B_DUP:  b_new = b_inc;
            RX_A_LOSS: a_new = a_dec;
            RX_B_LOSS: b_new = b_dec;
            default:   b_new = b_inc;
        endcase
        extinct_now = (a_new == '0) && (b_new == '0);
        slot_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next       = state_reg;
        rate_next        = rate_reg;
        end_time_next    = end_time_reg;
        scount_next      = scount_reg;
        species_a_next   = species_a_reg;
        species_b_next   = species_b_reg;
        sim_time_next    = sim_time_reg;
        next_sample_next = next_sample_reg;
        running_next     = running_reg;
        exp_next         = exp_reg;
        unif_next        = unif_reg;
        sum_idx_next     = sum_idx_reg;
        acc_next         = acc_reg;
        cum_next         = cum_reg;
        fault_next       = fault_reg;
        rsel_next        = rsel_reg;
        out_beat_next    = out_beat_reg;
        out_valid_next   = out_valid_reg && out_stall;
        mem_we           = 1'b0;
        lane_start       = 1'b0;
        unit_start       = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RATE_A_DUP, CFG_RATE_B_DUP, CFG_RATE_A_LOSS,
                CFG_RATE_B_LOSS, CFG_RATE_A_TO_B:
                    rate_next[cfg_index] = cfg_data;
                CFG_END_TIME:     end_time_next = cfg_data;
                CFG_SAMPLE_COUNT: scount_next   = cfg_data[SCOUNT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode_t'(in_beat.mode))
                        MODE_LOAD:
                            mem_we = (32'(in_beat.time_index) < MAX_SAMPLES);
                        MODE_START:
                        begin
                            species_a_next   = CB'(in_beat.init_a);
                            species_b_next   = CB'(in_beat.init_b);
                            sim_time_next    = '0;
                            next_sample_next = '0;
                            running_next     = 1'b1;
                        end
                        MODE_EVENT:
                        begin
                            if (running_reg)
                            begin
                                exp_next   = in_beat.exp_draw;
                                unif_next  = in_beat.unif_draw;
                                lane_start = 1'b1;
                                state_next = ST_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL:
            begin
                if (lane_busy == '0)
                begin
                    sum_idx_next = '0;
                    acc_next     = '0;
                    state_next   = ST_SUM;
                end
            end
            ST_SUM:
            begin
                acc_next              = acc_reg + TOT_W'(haz[sum_idx_reg]);
                cum_next[sum_idx_reg] = acc_next;
                sum_idx_next          = sum_idx_reg + 1'b1;
                if (sum_idx_reg == 3'(RATE_COUNT - 1))
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (cum_reg[RATE_COUNT-1] == '0)
                begin
                    fault_next = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    fault_next = 1'b0;
                    unit_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!div_busy && !tmul_busy)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                sim_time_next = newt[TIME_W] ? TIME_SAT : newt[TIME_W-1:0];
                if (target < cum_reg[0])
                    rsel_next = RX_A_DUP;
                else if (target < cum_reg[1])
                    rsel_next = RX_B_DUP;
                else if (target < cum_reg[2])
                    rsel_next = RX_A_LOSS;
                else if (target < cum_reg[3])
                    rsel_next = RX_B_LOSS;
                else
                    rsel_next = RX_A_TO_B;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_beat_next  = '0;
                    if (fault_reg)
                    begin
                        out_beat_next.finished     = 1'b1;
                        out_beat_next.hazard_fault = 1'b1;
                        running_next               = 1'b0;
                    end
                    else
                    begin
                        if (sample_hit)
                        begin
                            out_beat_next.sample_valid = 1'b1;
                            out_beat_next.sample_index = IDX_FIELD_W'(next_sample_reg);
                            out_beat_next.count_a      = CNT_FIELD_W'(species_a_reg);
                            out_beat_next.count_b      = CNT_FIELD_W'(species_b_reg);
                            next_sample_next           = next_sample_reg + 1'b1;
                        end
                        species_a_next = a_new;
                        species_b_next = b_new;
                        if (extinct_now)
                        begin
                            out_beat_next.extinct  = 1'b1;
                            out_beat_next.finished = 1'b1;
                            running_next           = 1'b0;
                        end
                        else if (sim_time_reg > end_time_reg)
                        begin
                            out_beat_next.finished = 1'b1;
                            running_next           = 1'b0;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rate_reg        <= '{default: '0};
            end_time_reg    <= '0;
            scount_reg      <= SAMPLE_COUNT_RST;
            species_a_reg   <= '0;
            species_b_reg   <= '0;
            sim_time_reg    <= '0;
            next_sample_reg <= '0;
            running_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rate_reg        <= rate_next;
            end_time_reg    <= end_time_next;
            scount_reg      <= scount_next;
            species_a_reg   <= species_a_next;
            species_b_reg   <= species_b_next;
            sim_time_reg    <= sim_time_next;
            next_sample_reg <= next_sample_next;
            running_reg     <= running_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg      <= exp_next;
        unif_reg     <= unif_next;
        sum_idx_reg  <= sum_idx_next;
        acc_reg      <= acc_next;
        cum_reg      <= cum_next;
        fault_reg    <= fault_next;
        rsel_reg     <= rsel_next;
        out_beat_reg <= out_beat_next;
    end

    // sample time table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_times[AW'(in_beat.time_index)] <= in_beat.time_value;
        end
        mem_rd_reg <= sample_times[next_sample_reg[AW-1:0]];
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    a_fault_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.hazard_fault |-> out_beat.finished && !out_beat.sample_valid)
        else $error("hazard fault beat without finish or with a sample");

    a_extinct_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.extinct |-> out_beat.finished && !out_beat.hazard_fault)
        else $error("extinct beat not marked finished");

    a_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !div_busy && !tmul_busy && (lane_busy == '0))
        else $error("serial unit busy while idle");

    a_run_stops: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && slot_free && fault_reg |=> !running_reg)
        else $error("run still active after hazard fault");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for the two-species gillespie step block
// depends on gsp_pkg and two_species_gillespie_step; a built-in event model predicts each result
`timescale 1ns / 1ps

module tb_top;
    import gsp_pkg::*;

    localparam int TABLE_DEPTH = 128;
    localparam int SETTLE      = 120;
    localparam int WATCHDOG    = 5000;
    localparam int ITEM_TARGET = 2000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_beat_t             in_beat;
    logic                 out_valid;
    logic                 out_stall;
    out_beat_t            out_beat;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RATE_W-1:0]    cfg_data;

    two_species_gillespie_step u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // event model state
    logic [31:0] rate_q [RATE_COUNT];
    logic [31:0] stop_time;
    logic [7:0]  n_points;
    logic [31:0] point_time [TABLE_DEPTH];
    logic [15:0] pop_a;
    logic [15:0] pop_b;
    logic [31:0] clock_now;
    int          next_point;
    bit          run_live;

    out_beat_t   event_results [$];
    out_beat_t   want;
    int          mismatches;
    int          items_sent;
    int          n_events;
    int          n_samples;
    int          n_extinct;
    int          n_faults;
    int          n_timeouts;
    int          idle_cycles;
    bit          calm;
    int          stall_hold;
    logic [31:0] time_step;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [15:0] grow16(input logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    function automatic bit model_step(input in_beat_t b, output out_beat_t r);
        logic [63:0] haz [RATE_COUNT];
        logic [63:0] cum [RATE_COUNT];
        logic [63:0] total;
        logic [63:0] dt;
        logic [63:0] newt;
        logic [63:0] unif;
        logic [63:0] target;
        int          pick;
        int          used;
        r = '0;
        case (mode_t'(b.mode))
            MODE_LOAD:
            begin
                point_time[b.time_index] = b.time_value;
                return 1'b0;
            end
            MODE_START:
            begin
                pop_a      = b.init_a;
                pop_b      = b.init_b;
                clock_now  = '0;
                next_point = 0;
                run_live   = 1'b1;
                return 1'b0;
            end
            MODE_EVENT:
            begin
                if (!run_live)
                    return 1'b0;
            end
            default: return 1'b0;
        endcase
        n_events++;
        total = '0;
        for (int i = 0; i < RATE_COUNT; i++)
        begin
            haz[i] = 64'(rate_q[i]) * 64'(LANE_USES_B[i] ? pop_b : pop_a);
            total  = total + haz[i];
            cum[i] = total;
        end
        if (total == 0)
        begin
            r.finished     = 1'b1;
            r.hazard_fault = 1'b1;
            run_live       = 1'b0;
            n_faults++;
            return 1'b1;
        end
        dt = (64'(b.exp_draw) << DRAW_SHIFT) / total;
        if (dt > 64'(TIME_SAT))
            dt = 64'(TIME_SAT);
        newt = 64'(clock_now) + dt;
        if (newt > 64'(TIME_SAT))
            newt = 64'(TIME_SAT);
        clock_now = newt[31:0];
        used = (n_points > TABLE_DEPTH) ? TABLE_DEPTH : int'(n_points);
        if (next_point < used && clock_now >= point_time[next_point])
        begin
            r.sample_valid = 1'b1;
            r.sample_index = next_point[6:0];
            r.count_a      = pop_a;
            r.count_b      = pop_b;
            next_point++;
            n_samples++;
        end
        unif   = 64'(b.unif_draw);
        target = unif * (total >> 32) + ((unif * (total & 64'hFFFF_FFFF)) >> 32);
        pick   = 4;
        for (int i = RATE_COUNT - 1; i >= 0; i--)
            if (target < cum[i])
                pick = i;
        case (pick)
            0: pop_a = grow16(pop_a);
            1: pop_b = grow16(pop_b);
            2: if (pop_a != 0) pop_a = pop_a - 16'd1;
            3: if (pop_b != 0) pop_b = pop_b - 16'd1;
            default: pop_b = grow16(pop_b);
        endcase
        if (pop_a == 0 && pop_b == 0)
        begin
            r.extinct  = 1'b1;
            r.finished = 1'b1;
            run_live   = 1'b0;
            n_extinct++;
        end
        else if (clock_now > stop_time)
        begin
            r.finished = 1'b1;
            run_live   = 1'b0;
            n_timeouts++;
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (event_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", out_beat);
            end
            else
            begin
                want = event_results.pop_front();
                if (out_beat.sample_valid !== want.sample_valid ||
                    out_beat.sample_index !== want.sample_index ||
                    out_beat.count_a !== want.count_a ||
                    out_beat.count_b !== want.count_b ||
                    out_beat.extinct !== want.extinct ||
                    out_beat.finished !== want.finished ||
                    out_beat.hazard_fault !== want.hazard_fault)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp sv=%0d idx=%0d a=%0d b=%0d ext=%0d fin=%0d hf=%0d",
                            want.sample_valid, want.sample_index, want.count_a,
                            want.count_b, want.extinct, want.finished, want.hazard_fault);
                        $display("          got sv=%0d idx=%0d a=%0d b=%0d ext=%0d fin=%0d hf=%0d",
                            out_beat.sample_valid, out_beat.sample_index, out_beat.count_a,
                            out_beat.count_b, out_beat.extinct, out_beat.finished,
                            out_beat.hazard_fault);
                    end
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        stall_hold = 0;
        forever
        begin
            @(posedge clk);
            if (stall_hold > 0)
                stall_hold--;
            else if (!calm && !out_stall && $urandom_range(0, 3) == 0)
            begin
                out_stall  <= 1'b1;
                stall_hold = pick_gap();
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_hold = $urandom_range(0, 20);
            end
        end
    end

    // watchdog
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog expired, %0d results outstanding", event_results.size());
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_beat(input in_beat_t b);
        out_beat_t r;
        int        gap;
        in_valid <= 1'b1;
        in_beat  <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (model_step(b, r))
            event_results.push_back(r);
        if (mode_t'(b.mode) != MODE_NONE)
            items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (event_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // drives one write beat; the caller drops cfg_valid after the last one
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_END_TIME:     stop_time = val;
            CFG_SAMPLE_COUNT: n_points = val[7:0];
            CFG_UNUSED:       ;
            default:          rate_q[idx] = val;
        endcase
    endtask

    task automatic set_config(input logic [31:0] r0, input logic [31:0] r1,
                              input logic [31:0] r2, input logic [31:0] r3,
                              input logic [31:0] r4, input logic [31:0] endt,
                              input logic [7:0] sc);
        wait_idle();
        write_reg(CFG_RATE_A_DUP, r0);
        write_reg(CFG_RATE_B_DUP, r1);
        write_reg(CFG_RATE_A_LOSS, r2);
        write_reg(CFG_RATE_B_LOSS, r3);
        write_reg(CFG_RATE_A_TO_B, r4);
        write_reg(CFG_END_TIME, endt);
        write_reg(CFG_SAMPLE_COUNT, {24'd0, sc});
        cfg_valid <= 1'b0;
    endtask

    function automatic in_beat_t mk_beat(input mode_t m);
        in_beat_t b;
        b.mode       = m;
        b.time_index = 7'($urandom);
        b.time_value = $urandom;
        b.init_a     = 16'($urandom);
        b.init_b     = 16'($urandom);
        b.exp_draw   = $urandom;
        b.unif_draw  = $urandom;
        return b;
    endfunction

    task automatic start_run(input logic [15:0] a, input logic [15:0] b);
        in_beat_t x;
        x        = mk_beat(MODE_START);
        x.init_a = a;
        x.init_b = b;
        send_beat(x);
    endtask

    task automatic fire_event(input logic [31:0] e, input logic [31:0] u);
        in_beat_t x;
        x           = mk_beat(MODE_EVENT);
        x.exp_draw  = e;
        x.unif_draw = u;
        send_beat(x);
    endtask

    task automatic load_table(input logic [31:0] step);
        in_beat_t x;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            x            = mk_beat(MODE_LOAD);
            x.time_index = i[6:0];
            x.time_value = (i == TABLE_DEPTH - 1 && step == 0) ? TIME_SAT : step * i;
            send_beat(x);
        end
    endtask

    task automatic test_reset_defaults();
        fire_event($urandom, $urandom);
        send_beat(mk_beat(MODE_NONE));
        load_table('0);
        start_run(16'd5, 16'd5);
        fire_event(32'h0100_0000, 32'h0);
    endtask

    task automatic test_corner_events();
        set_config(32'hFFFF_FFFF, 32'h1, 32'h1, 32'h1, 32'h1, TIME_SAT, 8'd121);
        start_run(16'hFFFF, 16'hFFFF);
        fire_event(32'hFFFF_FFFF, 32'h0);
        fire_event(32'h0, 32'hFFFF_FFFF);
        fire_event(32'h0100_0000, 32'h0);
        start_run(16'h0, 16'h0);
        fire_event(32'h0100_0000, 32'h8000_0000);
        set_config(32'h1, 32'h0, 32'h0, 32'h0, 32'h0, TIME_SAT, 8'd0);
        start_run(16'd1, 16'd0);
        fire_event(32'hFFFF_FFFF, 32'h0);
        fire_event(32'hFFFF_FFFF, 32'h0);
        set_config(32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h0, 8'd255);
        start_run(16'd1, 16'd0);
        fire_event(32'h0100_0000, 32'h1234_5678);
        set_config(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h0, 8'd1);
        start_run(16'd3, 16'd4);
        fire_event(32'h0, 32'hFFFF_FFFF);
        fire_event(32'h0, 32'h0);
        fire_event(32'h0100_0000, 32'h7FFF_FFFF);
    endtask

    function automatic logic [31:0] rand_rate();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return $urandom;
            default: return $urandom_range(32'h800, 32'h3_0000);
        endcase
    endfunction

    task automatic test_random_runs();
        int       phase;
        int       r;
        int       steps;
        in_beat_t x;
        logic [31:0] endt;
        logic [7:0]  sc;
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            endt = ($urandom_range(0, 3) == 0) ? $urandom : time_step * $urandom_range(10, 140);
            sc   = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(1, 128));
            set_config(rand_rate(), rand_rate(), rand_rate(), rand_rate(), rand_rate(), endt, sc);
            calm = ($urandom_range(0, 4) == 0);
            if (phase % 4 == 3)
            begin
                time_step = $urandom_range(16, 32'h4000);
                load_table(time_step);
            end
            repeat (3)
            begin
                if ($urandom_range(0, 4) == 0)
                    start_run(16'($urandom), 16'($urandom));
                else
                    start_run(16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)));
                steps = 0;
                while (run_live && steps < 40)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        send_beat(mk_beat(MODE_NONE));
                    else if (r < 6)
                    begin
                        x            = mk_beat(MODE_LOAD);
                        x.time_value = time_step * x.time_index;
                        send_beat(x);
                    end
                    else
                        fire_event($urandom, $urandom);
                    steps++;
                end
                if ($urandom_range(0, 3) == 0)
                    fire_event($urandom, $urandom);
            end
            phase++;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_beat    = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        calm       = 1'b0;
        mismatches = 0;
        items_sent = 0;
        n_events   = 0;
        n_samples  = 0;
        n_extinct  = 0;
        n_faults   = 0;
        n_timeouts = 0;
        time_step  = 32'h100;
        for (int i = 0; i < RATE_COUNT; i++)
            rate_q[i] = '0;
        stop_time  = '0;
        n_points   = SAMPLE_COUNT_RST;
        pop_a      = '0;
        pop_b      = '0;
        clock_now  = '0;
        next_point = 0;
        run_live   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_corner_events();
        load_table(time_step);
        test_random_runs();
        wait_idle();

        $display("%0d beats sent, %0d events, %0d samples recorded", items_sent, n_events,
                 n_samples);
        $display("runs ended: %0d extinct, %0d past end time, %0d zero hazard",
                 n_extinct, n_timeouts, n_faults);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/gsp_pkg.sv
rtl/gsp_mul.sv
rtl/gsp_div.sv
rtl/two_species_gillespie_step.sv
tb/tb_top.sv
